/* design/skvm_pkg.sv */
package skvm_pkg;

    localparam int TABLE_SLOTS     = 16;
    localparam int BREAKPOINTS_DEF = 10;
    localparam int READING_W       = 10;
    localparam int VOLUME_W        = 7;
    localparam int BYTE_W          = 8;
    localparam int NUM_W           = 13;
    localparam int DEN_W           = 10;
    localparam int SEG_W           = $clog2(TABLE_SLOTS);
    localparam int SUM_W           = 8;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [BYTE_W-1:0]   START_CHAR_RST  = 8'd97;
    localparam logic [VOLUME_W-1:0] BASE_VOLUME_RST = 7'd50;
    localparam logic [BYTE_W-1:0]   CHAR_ZERO       = 8'h30;
    localparam logic [BYTE_W-1:0]   CHAR_NINE       = 8'h39;
    localparam logic [SUM_W-1:0]    VOLUME_MAX      = 8'd100;
    localparam logic [READING_W-1:0] READING_MAX    = 10'd999;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_CHAR  = 2'd0,
        CFG_BASE_VOLUME = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_stat;

    function automatic logic [READING_W-1:0] bp_value(input logic [SEG_W-1:0] idx);
        logic [READING_W-1:0] v;
        case (idx)
            4'd0:    v = 10'd35;
            4'd1:    v = 10'd50;
            4'd2:    v = 10'd70;
            4'd3:    v = 10'd100;
            4'd4:    v = 10'd200;
            4'd5:    v = 10'd300;
            4'd6:    v = 10'd400;
            4'd7:    v = 10'd500;
            4'd8:    v = 10'd750;
            4'd9:    v = 10'd950;
            default: v = 10'd1000;
        endcase
        return v;
    endfunction

endpackage

/* design/skvm_div.sv */
module skvm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  skvm_pkg::t_div_req  i_req,
    output skvm_pkg::t_div_stat o_stat
);

    localparam int CNT_W = $clog2(skvm_pkg::NUM_W + 1);

    logic [CNT_W-1:0]              r_cnt;
    logic                          r_done;
    logic [skvm_pkg::NUM_W-1:0]    r_dvd;
    logic [skvm_pkg::DEN_W-1:0]    r_rem;
    logic [skvm_pkg::DEN_W-1:0]    r_den;
    logic [skvm_pkg::DEN_W:0]      shifted;
    logic [skvm_pkg::DEN_W:0]      diff;
    logic                          fits;

    assign shifted = {r_rem, r_dvd[skvm_pkg::NUM_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_cnt <= CNT_W'(skvm_pkg::NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[skvm_pkg::NUM_W-2:0], fits};
            r_rem <= fits ? diff[skvm_pkg::DEN_W-1:0] : shifted[skvm_pkg::DEN_W-1:0];
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_stat.quot = r_dvd;

endmodule

/* design/serial_knob_volume_mapper.sv */
// flow: a start or non-final byte is accepted whenever the mapper is idle; the third digit of a frame
// gives its result after setup, the divider steps, finish and hold, and hold waits for a free output
// throughput: one byte per cycle between frames; the third digit holds the input off until its
// result is passed to the output, so the bit-serial divider and the output bound the frame rate
// reset: synchronous active low; hunting for the start character, config registers at defaults
module serial_knob_volume_mapper #(
    parameter int BREAKPOINTS = skvm_pkg::BREAKPOINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [skvm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [skvm_pkg::BYTE_W-1:0]         i_cfg_data,
    input  logic                                i_rx_valid,
    output logic                                o_rx_ready,
    input  logic [skvm_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [skvm_pkg::VOLUME_W-1:0]       o_volume_percent,
    output logic [skvm_pkg::READING_W-1:0]      o_knob_reading
);

    localparam int BP_N = (BREAKPOINTS < 2) ? 2 :
                          ((BREAKPOINTS > skvm_pkg::TABLE_SLOTS) ? skvm_pkg::TABLE_SLOTS
                                                                 : BREAKPOINTS);
    localparam logic [skvm_pkg::SEG_W-1:0] SEG_LAST = skvm_pkg::SEG_W'(BP_N - 1);

    skvm_pkg::t_state                   r_state, n_state;
    logic [1:0]                         r_phase, n_phase;
    logic [skvm_pkg::READING_W-1:0]     r_acc, n_acc;
    logic [skvm_pkg::READING_W-1:0]     r_reading, n_reading;
    logic [skvm_pkg::SEG_W-1:0]         r_seg, n_seg;
    logic                               r_below, n_below;
    logic [skvm_pkg::VOLUME_W-1:0]      r_vol, n_vol;
    logic [skvm_pkg::BYTE_W-1:0]        r_start_char;
    logic [skvm_pkg::VOLUME_W-1:0]      r_base_volume;
    logic                               r_res_valid, n_res_valid;
    logic [skvm_pkg::VOLUME_W-1:0]      r_res_vol, n_res_vol;
    logic [skvm_pkg::READING_W-1:0]     r_res_reading, n_res_reading;

    skvm_pkg::t_div_req                 div_req;
    skvm_pkg::t_div_stat                div_stat;

    logic                               rx_fire;
    logic                               is_digit;
    logic [skvm_pkg::BYTE_W-1:0]        digit;
    logic [skvm_pkg::READING_W+3:0]     acc_next_wide;
    logic                               seg_found;
    logic [skvm_pkg::SEG_W-1:0]         seg_idx;
    logic [skvm_pkg::READING_W-1:0]     seg_lo;
    logic [skvm_pkg::READING_W-1:0]     seg_hi;
    logic [skvm_pkg::READING_W-1:0]     span;
    logic [skvm_pkg::READING_W-1:0]     offset;
    logic [skvm_pkg::SUM_W-1:0]         vol_sum;
    logic                               out_free;

    skvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    assign rx_fire  = i_rx_valid && o_rx_ready;
    assign is_digit = (i_rx_byte >= skvm_pkg::CHAR_ZERO)
                   && (i_rx_byte <= skvm_pkg::CHAR_NINE);
    assign digit    = i_rx_byte - skvm_pkg::CHAR_ZERO;
    assign acc_next_wide = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                         + {6'b0, digit};
    assign out_free = !r_res_valid || i_res_ready;

    // first segment whose upper breakpoint lies above the reading
    always_comb begin
        seg_found = 1'b0;
        seg_idx   = '0;
        for (int k = 1; k < skvm_pkg::TABLE_SLOTS; k++) begin
            if (k < BP_N && !seg_found
                && r_reading < skvm_pkg::bp_value(skvm_pkg::SEG_W'(k))) begin
                seg_found = 1'b1;
                seg_idx   = skvm_pkg::SEG_W'(k - 1);
            end
        end
    end

    assign seg_lo = skvm_pkg::bp_value(seg_idx);
    assign seg_hi = skvm_pkg::bp_value(seg_idx + skvm_pkg::SEG_W'(1));
    assign span   = seg_hi - seg_lo;
    assign offset = r_reading - seg_lo;

    assign vol_sum = skvm_pkg::SUM_W'(r_base_volume)
                   + skvm_pkg::SUM_W'({r_seg, 2'b00}) + skvm_pkg::SUM_W'(r_seg)
                   + skvm_pkg::SUM_W'(div_stat.quot);

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_acc         = r_acc;
        n_reading     = r_reading;
        n_seg         = r_seg;
        n_below       = r_below;
        n_vol         = r_vol;
        n_res_valid   = r_res_valid && !i_res_ready;
        n_res_vol     = r_res_vol;
        n_res_reading = r_res_reading;
        o_rx_ready    = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = skvm_pkg::DEN_W'(1);

        unique case (r_state)
            skvm_pkg::ST_IDLE: begin
                o_rx_ready = 1'b1;
                if (rx_fire) begin
                    if (r_phase == 2'd0) begin
                        if (i_rx_byte == r_start_char) begin
                            n_phase = 2'd1;
                            n_acc   = '0;
                        end
                    end else if (!is_digit) begin
                        n_phase = 2'd0;
                    end else begin
                        n_acc = acc_next_wide[skvm_pkg::READING_W-1:0];
                        if (r_phase == 2'd3) begin
                            n_phase   = 2'd0;
                            n_reading = acc_next_wide[skvm_pkg::READING_W-1:0];
                            n_state   = skvm_pkg::ST_SETUP;
                        end else begin
                            n_phase = r_phase + 2'd1;
                        end
                    end
                end
            end
            skvm_pkg::ST_SETUP: begin
                n_below       = r_reading < skvm_pkg::bp_value('0);
                n_seg         = seg_found ? seg_idx : SEG_LAST;
                div_req.start = 1'b1;
                if (seg_found && span != '0) begin
                    div_req.num = skvm_pkg::NUM_W'({offset, 2'b00})
                                + skvm_pkg::NUM_W'(offset);
                    div_req.den = span;
                end
                n_state = skvm_pkg::ST_DIV;
            end
            skvm_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    if (r_below) begin
                        n_vol = '0;
                    end else if (vol_sum > skvm_pkg::VOLUME_MAX) begin
                        n_vol = skvm_pkg::VOLUME_W'(skvm_pkg::VOLUME_MAX);
                    end else begin
                        n_vol = vol_sum[skvm_pkg::VOLUME_W-1:0];
                    end
                    n_state = skvm_pkg::ST_HOLD;
                end
            end
            skvm_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_res_valid   = 1'b1;
                    n_res_vol     = r_vol;
                    n_res_reading = r_reading;
                    n_state       = skvm_pkg::ST_IDLE;
                end
            end
            default: n_state = skvm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skvm_pkg::ST_IDLE;
            r_phase     <= 2'd0;
            r_acc       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reading     <= n_reading;
        r_seg         <= n_seg;
        r_below       <= n_below;
        r_vol         <= n_vol;
        r_res_vol     <= n_res_vol;
        r_res_reading <= n_res_reading;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char  <= skvm_pkg::START_CHAR_RST;
            r_base_volume <= skvm_pkg::BASE_VOLUME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                skvm_pkg::CFG_START_CHAR:  r_start_char  <= i_cfg_data;
                skvm_pkg::CFG_BASE_VOLUME:
                    r_base_volume <= i_cfg_data[skvm_pkg::VOLUME_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_volume_percent = r_res_vol;
    assign o_knob_reading   = r_res_reading;

`ifndef NO_ASSERTIONS
    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (7'(o_volume_percent) <= 7'(skvm_pkg::VOLUME_MAX)))
        else $error("volume above saturation limit");

    a_reading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_knob_reading <= skvm_pkg::READING_MAX))
        else $error("knob reading out of range");

    a_div_idle_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvm_pkg::ST_IDLE || r_state == skvm_pkg::ST_HOLD) |-> !div_stat.busy)
        else $error("divider busy outside divide phase");

    a_div_to_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvm_pkg::ST_DIV && div_stat.done) |=> (r_state == skvm_pkg::ST_HOLD))
        else $error("divide finish did not reach hold");
`endif

endmodule
